@@ rtl/tdl_pkg.sv @@
// ----------------------------------------------------------------------------
// tdl_pkg: shared definitions for the tree distance engine
// Field widths, default sizes, operation codes and the sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tdl_pkg;

    localparam int NODE_W   = 10;
    localparam int WEIGHT_W = 16;
    localparam int DIST_W   = 32;

    localparam int DEF_MAX_NODES   = 1024;
    localparam int DEF_LIFT_LEVELS = 11;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } tdl_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ROOT,
        S_ADD_INFO,
        S_ADD_LINK,
        S_ADD_RD,
        S_ADD_WR,
        S_Q_INFO,
        S_Q_SWAP,
        S_LIFT,
        S_LIFT_WT,
        S_CHECK,
        S_DESC_RD,
        S_DESC_CMP,
        S_ANC_RD,
        S_ANC_WT,
        S_DIST_RD,
        S_DIST_WT,
        S_DONE
    } tdl_state_t;

endpackage

`default_nettype wire

@@ rtl/tdl_ram.sv @@
// ----------------------------------------------------------------------------
// tdl_ram: generic synchronous RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tdl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_a,
    output logic      [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Reads return the contents from before a same-cycle write.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

@@ rtl/tree_distance_lca_binary_lifting.sv @@
// ----------------------------------------------------------------------------
// tree_distance_lca_binary_lifting: weighted tree distance engine
// Builds a tree node by node and answers path-length queries through a
// binary-lifting lowest common ancestor search held in two RAMs.
// ----------------------------------------------------------------------------
// Usage.
// The request channel (req_valid/req_ready) carries one transaction per item:
// op, node, other_node and weight. An add (op = 0) attaches node under
// other_node with the given edge weight; a node added under itself becomes a
// root. Parents must be added before their children. A query (op = 1) returns
// one transaction on the response channel (rsp_valid/rsp_ready) holding the
// path length and the lowest common ancestor of node and other_node. Adds and
// queries with a node at or above MAX_NODES give no response.
// The block works on one transaction at a time; req_ready is high while the
// sequencer is idle. Every step is paced by the registered RAM read:
//   root add  : the node written as its own ancestor on every level
//   child add : the parent's information read, then one read and one write
//               per jump level above level 0
//   query     : lifting (an extra step for each set bit of the depth difference),
//               then descent, skipped when the lifted node equals the other one.
// A finished response sits in an output register; the next request is taken
// while it waits. If the receiver stalls with a response still pending, the
// following query holds in its last step until the register frees up.
// Reset clears the sequencer and the response valid only; the RAMs are not
// cleared, and a node must be added before it is read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tree_distance_lca_binary_lifting
    import tdl_pkg::*;
#(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int LIFT_LEVELS = DEF_LIFT_LEVELS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire logic                op,
    input  wire logic [NODE_W-1:0]   node,
    input  wire logic [NODE_W-1:0]   other_node,
    input  wire logic [WEIGHT_W-1:0] weight,

    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output logic [DIST_W-1:0]        distance,
    output logic [NODE_W-1:0]        ancestor
);

    // Derived sizes.
    localparam int NODE_AW  = $clog2(MAX_NODES);
    localparam int DEPTH_W  = $clog2(MAX_NODES);
    localparam int JT_DEPTH = MAX_NODES * LIFT_LEVELS;
    localparam int JT_AW    = $clog2(JT_DEPTH);
    localparam int LVL_W    = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int INFO_W   = DEPTH_W + DIST_W;

    localparam logic [LVL_W-1:0]   LVL_LAST  = LVL_W'(LIFT_LEVELS - 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_NODES - 1);

    typedef logic [LIFT_LEVELS-1:0] diff_t;

    // Entry address of ancestor level l of node n.
    function automatic logic [JT_AW-1:0] jt_addr(input logic [NODE_W-1:0] n,
                                                 input logic [LVL_W-1:0]  l);
        return JT_AW'(n) * JT_AW'(LIFT_LEVELS) + JT_AW'(l);
    endfunction

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    tdl_state_t            state_reg, state_next;
    logic [LVL_W-1:0]      lvl_reg, lvl_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    logic [NODE_W-1:0]     node_reg, node_next;
    logic [NODE_W-1:0]     oth_reg, oth_next;
    logic [WEIGHT_W-1:0]   weight_reg, weight_next;
    logic [NODE_W-1:0]     mid_reg, mid_next;
    logic [NODE_W-1:0]     u_reg, u_next;
    logic [NODE_W-1:0]     v_reg, v_next;
    diff_t                 diff_reg, diff_next;
    logic [DIST_W-1:0]     sum_reg, sum_next;
    logic [NODE_W-1:0]     anc_reg, anc_next;
    logic [DIST_W-1:0]     anc_dist_reg, anc_dist_next;
    logic [DIST_W-1:0]     distance_reg, distance_next;
    logic [NODE_W-1:0]     ancestor_reg, ancestor_next;

    // ------------------------------------------------------------------
    // Memories: the jump table and the per-node {depth, root distance}.
    // ------------------------------------------------------------------
    logic                  jt_we;
    logic [JT_AW-1:0]      jt_waddr, jt_raddr_a, jt_raddr_b;
    logic [NODE_W-1:0]     jt_wdata, jt_rdata_a, jt_rdata_b;

    logic                  info_we;
    logic [NODE_AW-1:0]    info_waddr, info_raddr_a, info_raddr_b;
    logic [INFO_W-1:0]     info_wdata, info_rdata_a, info_rdata_b;

    tdl_ram #(
        .WIDTH (NODE_W),
        .DEPTH (JT_DEPTH)
    ) u_jump_ram (
        .clk     (clk),
        .we      (jt_we),
        .waddr   (jt_waddr),
        .wdata   (jt_wdata),
        .raddr_a (jt_raddr_a),
        .raddr_b (jt_raddr_b),
        .rdata_a (jt_rdata_a),
        .rdata_b (jt_rdata_b)
    );

    tdl_ram #(
        .WIDTH (INFO_W),
        .DEPTH (MAX_NODES)
    ) u_info_ram (
        .clk     (clk),
        .we      (info_we),
        .waddr   (info_waddr),
        .wdata   (info_wdata),
        .raddr_a (info_raddr_a),
        .raddr_b (info_raddr_b),
        .rdata_a (info_rdata_a),
        .rdata_b (info_rdata_b)
    );

    // Fields of the node information words as they come out of the RAM.
    logic [DEPTH_W-1:0] depth_a, depth_b;
    logic [DIST_W-1:0]  dist_a, dist_b;
    logic [DEPTH_W-1:0] depth_diff;
    logic               a_deeper;
    logic [DEPTH_W-1:0] child_depth;
    logic               nodes_ok;

    assign depth_a  = info_rdata_a[INFO_W-1:DIST_W];
    assign depth_b  = info_rdata_b[INFO_W-1:DIST_W];
    assign dist_a   = info_rdata_a[DIST_W-1:0];
    assign dist_b   = info_rdata_b[DIST_W-1:0];
    assign a_deeper = depth_a > depth_b;
    assign depth_diff = a_deeper ? (depth_a - depth_b) : (depth_b - depth_a);

    // A child sits one level below its parent, saturating at the deepest level.
    assign child_depth = (depth_a >= DEPTH_MAX) ? DEPTH_MAX : (depth_a + DEPTH_W'(1));

    assign nodes_ok = (32'(node) < MAX_NODES) && (32'(other_node) < MAX_NODES);

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign distance  = distance_reg;
    assign ancestor  = ancestor_reg;

    // ------------------------------------------------------------------
    // Sequencer: next state, memory controls and register updates.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        node_next      = node_reg;
        oth_next       = oth_reg;
        weight_next    = weight_reg;
        mid_next       = mid_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        diff_next      = diff_reg;
        sum_next       = sum_reg;
        anc_next       = anc_reg;
        anc_dist_next  = anc_dist_reg;
        distance_next  = distance_reg;
        ancestor_next  = ancestor_reg;

        jt_we        = 1'b0;
        jt_waddr     = jt_addr(node_reg, lvl_reg);
        jt_wdata     = node_reg;
        jt_raddr_a   = jt_addr(u_reg, lvl_reg);
        jt_raddr_b   = jt_addr(v_reg, lvl_reg);

        info_we      = 1'b0;
        info_waddr   = NODE_AW'(node_reg);
        info_wdata   = '0;
        info_raddr_a = NODE_AW'(node_reg);
        info_raddr_b = NODE_AW'(oth_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    node_next   = node;
                    oth_next    = other_node;
                    weight_next = weight;
                    lvl_next    = '0;
                    if (!nodes_ok)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (op == OP_QUERY)
                    begin
                        state_next = S_Q_INFO;
                    end
                    else if (node == other_node)
                    begin
                        state_next = S_ROOT;
                    end
                    else
                    begin
                        state_next = S_ADD_INFO;
                    end
                end
            end

            // A root points at itself on every level.
            S_ROOT:
            begin
                jt_we   = 1'b1;
                info_we = 1'b1;
                if (lvl_reg == LVL_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    lvl_next = lvl_reg + LVL_W'(1);
                end
            end

            // Read the parent's information; level 0 is the parent itself.
            S_ADD_INFO:
            begin
                info_raddr_a = NODE_AW'(oth_reg);
                jt_we        = 1'b1;
                jt_wdata     = oth_reg;
                state_next   = S_ADD_LINK;
            end

            S_ADD_LINK:
            begin
                info_we    = 1'b1;
                info_wdata = {child_depth, dist_a + DIST_W'(weight_reg)};
                mid_next   = oth_reg;
                if (lvl_reg == LVL_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    lvl_next   = lvl_reg + LVL_W'(1);
                    state_next = S_ADD_RD;
                end
            end

            // Level l of the new node is level l-1 of its level l-1 ancestor.
            S_ADD_RD:
            begin
                jt_raddr_a = jt_addr(mid_reg, lvl_reg - LVL_W'(1));
                state_next = S_ADD_WR;
            end

            S_ADD_WR:
            begin
                jt_we    = 1'b1;
                jt_wdata = jt_rdata_a;
                mid_next = jt_rdata_a;
                if (lvl_reg == LVL_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    lvl_next   = lvl_reg + LVL_W'(1);
                    state_next = S_ADD_RD;
                end
            end

            S_Q_INFO:
            begin
                state_next = S_Q_SWAP;
            end

            // u is the shallower node, v the deeper one.
            S_Q_SWAP:
            begin
                sum_next  = dist_a + dist_b;
                diff_next = diff_t'(depth_diff);
                if (a_deeper)
                begin
                    u_next = oth_reg;
                    v_next = node_reg;
                end
                else
                begin
                    u_next = node_reg;
                    v_next = oth_reg;
                end
                lvl_next   = '0;
                state_next = S_LIFT;
            end

            S_LIFT:
            begin
                if (diff_reg[0])
                begin
                    state_next = S_LIFT_WT;
                end
                else
                begin
                    diff_next = diff_reg >> 1;
                    if (lvl_reg == LVL_LAST)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        lvl_next = lvl_reg + LVL_W'(1);
                    end
                end
            end

            S_LIFT_WT:
            begin
                v_next    = jt_rdata_b;
                diff_next = diff_reg >> 1;
                if (lvl_reg == LVL_LAST)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    lvl_next   = lvl_reg + LVL_W'(1);
                    state_next = S_LIFT;
                end
            end

            S_CHECK:
            begin
                if (u_reg == v_reg)
                begin
                    anc_next   = u_reg;
                    state_next = S_DIST_RD;
                end
                else
                begin
                    lvl_next   = LVL_LAST;
                    state_next = S_DESC_RD;
                end
            end

            S_DESC_RD:
            begin
                state_next = S_DESC_CMP;
            end

            // Jump both nodes while their ancestors at this level differ.
            S_DESC_CMP:
            begin
                if (jt_rdata_a != jt_rdata_b)
                begin
                    u_next = jt_rdata_a;
                    v_next = jt_rdata_b;
                end
                if (lvl_reg == '0)
                begin
                    state_next = S_ANC_RD;
                end
                else
                begin
                    lvl_next   = lvl_reg - LVL_W'(1);
                    state_next = S_DESC_RD;
                end
            end

            S_ANC_RD:
            begin
                state_next = S_ANC_WT;
            end

            S_ANC_WT:
            begin
                anc_next   = jt_rdata_a;
                state_next = S_DIST_RD;
            end

            S_DIST_RD:
            begin
                info_raddr_a = NODE_AW'(anc_reg);
                state_next   = S_DIST_WT;
            end

            S_DIST_WT:
            begin
                anc_dist_next = dist_a;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    distance_next  = sum_reg - {anc_dist_reg[DIST_W-2:0], 1'b0};
                    ancestor_next  = anc_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lvl_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Working values and the response payload.
    always_ff @(posedge clk)
    begin
        node_reg     <= node_next;
        oth_reg      <= oth_next;
        weight_reg   <= weight_next;
        mid_reg      <= mid_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        diff_reg     <= diff_next;
        sum_reg      <= sum_next;
        anc_reg      <= anc_next;
        anc_dist_reg <= anc_dist_next;
        distance_reg <= distance_next;
        ancestor_reg <= ancestor_next;
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // Lifting consumes every bit of the depth difference.
    a_lift_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (diff_reg == '0))
        else $error("depth difference not fully consumed by lifting");

    // Only add sequences write the memories.
    a_write_in_add: assert property (@(posedge clk) disable iff (!rst_n)
        (jt_we || info_we) |-> (state_reg == S_ROOT || state_reg == S_ADD_INFO ||
                                state_reg == S_ADD_LINK || state_reg == S_ADD_WR))
        else $error("memory write outside an add sequence");

    // A response appears only as a query finishes.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response raised outside the final query step");

    // The level counter stays inside the table.
    a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_reg <= LVL_LAST)
        else $error("level counter out of range");

endmodule

`default_nettype wire

@@ tb/tree_distance_lca_binary_lifting_test.sv @@
// ----------------------------------------------------------------------------
// tree_distance_lca_binary_lifting_test: self-checking bench for the engine
// Builds trees through add transactions and checks every query response
// against typed-in answers or a model of depth, root distance and jump tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tree_distance_lca_binary_lifting_test;

    import tdl_pkg::*;

    localparam int NODES  = DEF_MAX_NODES;
    localparam int LEVELS = DEF_LIFT_LEVELS;

    // This margin covers an add still running in the sequencer after the last
    // response.
    localparam int          SETTLE_CYCLES   = 80;
    localparam int          NUM_ROWS        = 21;
    localparam int          HOLD_CYCLES     = 600;
    localparam int unsigned RUN_CYCLE_LIMIT = 2_000_000;

    localparam bit TYPED     = 1'b1;
    localparam bit PREDICTED = 1'b0;

    typedef logic [NODE_W-1:0]   node_t;
    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic [DIST_W-1:0]   dist_t;

    // One request transaction plus, for directed rows, the typed-in answer.
    typedef struct packed {
        tdl_op_t kind;
        node_t   a;
        node_t   b;
        weight_t w;
        bit      typed;
        dist_t   path_len;
        node_t   anc;
    } stim_row_t;

    typedef struct packed {
        dist_t path_len;
        node_t anc;
    } path_result_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals around the block. Every input has a known
    // value from time zero.
    // ------------------------------------------------------------------------
    logic    clk        = 1'b0;
    logic    rst_n      = 1'b0;
    logic    req_valid  = 1'b0;
    logic    op         = 1'b0;
    node_t   node       = '0;
    node_t   other_node = '0;
    weight_t weight     = '0;
    logic    rsp_ready  = 1'b0;
    logic    req_ready;
    logic    rsp_valid;
    dist_t   distance;
    node_t   ancestor;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tree_distance_lca_binary_lifting u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .op         (op),
        .node       (node),
        .other_node (other_node),
        .weight     (weight),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .distance   (distance),
        .ancestor   (ancestor)
    );

    // ------------------------------------------------------------------------
    // Predictor state: our own copy of the three tables. Entries start
    // unknown (X), but the stimulus never reads one that it has not written.
    // ------------------------------------------------------------------------
    node_t anc_of      [NODES][LEVELS];
    node_t depth_of    [NODES];
    dist_t rootdist_of [NODES];

    // Nodes added so far; queries and parents are drawn only from these.
    bit    is_built   [NODES];
    node_t built_list [$];
    node_t last_added = '0;

    path_result_t expected_paths [$];

    int unsigned cycle_count   = 0;
    int unsigned fail_count    = 0;
    bit          quiet_mode    = 1'b0;
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;
    int unsigned rsp_hold_left = 0;
    int unsigned rsp_stall_left = 0;
    path_result_t rsp_want;

    // Attach child under parent. A node under itself becomes a root whose
    // every jump level points back to itself. Re-adding simply overwrites;
    // rows already derived from the old entries are left stale on purpose.
    function automatic void tree_attach(node_t child, node_t parent, weight_t w);
        node_t mid;
        if (child == parent)
        begin
            depth_of[child]    = '0;
            rootdist_of[child] = '0;
            for (int lvl = 0; lvl < LEVELS; lvl++)
                anc_of[child][lvl] = child;
            return;
        end
        // Depth saturates at the last node index instead of wrapping.
        if (depth_of[parent] >= node_t'(NODES - 1))
            depth_of[child] = node_t'(NODES - 1);
        else
            depth_of[child] = depth_of[parent] + node_t'(1);
        rootdist_of[child] = rootdist_of[parent] + dist_t'(w);
        anc_of[child][0] = parent;
        for (int lvl = 1; lvl < LEVELS; lvl++)
        begin
            mid = anc_of[child][lvl - 1];
            anc_of[child][lvl] = anc_of[mid][lvl - 1];
        end
    endfunction

    // Lowest common ancestor by binary lifting, then the path length. The
    // distance is taken modulo 2^32, so stale re-added entries may wrap.
    function automatic path_result_t path_query(node_t a, node_t b);
        node_t              x;
        node_t              y;
        node_t              t;
        node_t              dd;
        logic [LEVELS-1:0]  lift_bits;
        path_result_t       r;
        x = a;
        y = b;
        if (depth_of[x] > depth_of[y])
        begin
            t = x;
            x = y;
            y = t;
        end
        // Bits of the depth difference above the top jump level drop out.
        dd        = depth_of[y] - depth_of[x];
        lift_bits = LEVELS'(dd);
        for (int lvl = 0; lvl < LEVELS; lvl++)
            if (lift_bits[lvl])
                y = anc_of[y][lvl];
        if (x != y)
        begin
            for (int lvl = LEVELS - 1; lvl >= 0; lvl--)
            begin
                if (anc_of[x][lvl] != anc_of[y][lvl])
                begin
                    x = anc_of[x][lvl];
                    y = anc_of[y][lvl];
                end
            end
            x = anc_of[x][0];
        end
        r.anc      = x;
        r.path_len = rootdist_of[a] + rootdist_of[b] - (rootdist_of[x] << 1);
        return r;
    endfunction

    function automatic void note_failure(string msg);
        if (fail_count < 10)
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
        fail_count++;
    endfunction

    // Idle lengths: mostly none, often short, now and then a long gap.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Weights lean on the extremes so that every bit toggles and the
    // zero-weight edge shows up often.
    function automatic weight_t rand_weight();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return '1;
        else
            return weight_t'($urandom_range(0, 65535));
    endfunction

    function automatic node_t any_built();
        return built_list[$urandom_range(0, built_list.size() - 1)];
    endfunction

    function automatic stim_row_t make_row(tdl_op_t kind, node_t a, node_t b,
                                           weight_t w, bit typed, dist_t d,
                                           node_t anc);
        stim_row_t row;
        row.kind     = kind;
        row.a        = a;
        row.b        = b;
        row.w        = w;
        row.typed    = typed;
        row.path_len = d;
        row.anc      = anc;
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Request side. Inputs change only by nonblocking assignment at a rising
    // edge, and valid holds with a steady payload until the transaction is
    // taken. The predictor runs at the edge where it is accepted.
    // ------------------------------------------------------------------------
    task automatic send_item(input stim_row_t item);
        int unsigned  gap;
        path_result_t want;
        gap = quiet_mode ? 0 : pick_gap();
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid  <= 1'b1;
        op         <= item.kind;
        node       <= item.a;
        other_node <= item.b;
        weight     <= item.w;
        do
            @(posedge clk);
        while (!req_ready);
        if (item.kind == OP_QUERY)
        begin
            if (item.typed)
            begin
                want.path_len = item.path_len;
                want.anc      = item.anc;
            end
            else
                want = path_query(item.a, item.b);
            expected_paths = {expected_paths, want};
        end
        else
        begin
            tree_attach(item.a, item.b, item.w);
            if (!is_built[item.a])
            begin
                is_built[item.a] = 1'b1;
                built_list = {built_list, item.a};
            end
            last_added = item.a;
        end
    endtask

    task automatic send_add(node_t a, node_t b, weight_t w);
        send_item(make_row(OP_ADD, a, b, w, PREDICTED, '0, '0));
    endtask

    task automatic send_query(node_t a, node_t b);
        send_item(make_row(OP_QUERY, a, b, rand_weight(), PREDICTED, '0, '0));
    endtask

    // Mixed traffic over the nodes built so far. Half of the child adds hang
    // off the node added last, which grows chains well past the first levels.
    task automatic send_random_item();
        int unsigned roll;
        node_t       child;
        node_t       parent;
        roll = $urandom_range(0, 99);
        if (roll < 45)
        begin
            child = any_built();
            parent = ($urandom_range(0, 9) == 0) ? child : any_built();
            send_query(child, parent);
        end
        else if (roll < 50)
        begin
            child = node_t'($urandom_range(0, NODES - 1));
            send_add(child, child, rand_weight());
        end
        else
        begin
            child = node_t'($urandom_range(0, NODES - 1));
            // Mostly fresh nodes; the rest become re-adds.
            if (is_built[child] && $urandom_range(0, 3) != 0)
                child = node_t'($urandom_range(0, NODES - 1));
            parent = ($urandom_range(0, 1) == 0) ? last_added : any_built();
            send_add(child, parent, rand_weight());
        end
    endtask

    // Pause the sender until every query has been answered, then let the
    // sequencer finish whatever add it may still be working on.
    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (expected_paths.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Response side. Ready drops at random; on request it also holds off for
    // a long stretch so that one response parks in the output register and
    // the next query backs up into the request channel.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (hold_served != hold_requests)
            begin
                hold_served++;
                rsp_hold_left = HOLD_CYCLES;
            end
            if (rsp_hold_left != 0)
            begin
                rsp_hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (quiet_mode)
                rsp_ready <= 1'b1;
            else if (rsp_stall_left != 0)
            begin
                rsp_stall_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                rsp_stall_left = pick_gap();
            end
        end
    end

    // Every accepted response is matched with the oldest outstanding query.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_paths.size() == 0)
                note_failure($sformatf("unexpected response: distance %0d ancestor %0d",
                                       distance, ancestor));
            else
            begin
                rsp_want = expected_paths.pop_front();
                if (rsp_want.path_len !== distance || rsp_want.anc !== ancestor)
                    note_failure($sformatf({"query mismatch: expected distance %0d ",
                                            "ancestor %0d, got distance %0d ancestor %0d"},
                                           rsp_want.path_len, rsp_want.anc,
                                           distance, ancestor));
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        stim_row_t   directed_rows [NUM_ROWS];
        node_t       chain_order   [NODES];
        node_t       swap_tmp;
        int unsigned pick;

        // Directed rows. Answers are typed in where they follow directly from
        // the tree: a lone root, a single edge of full weight, a zero-weight
        // edge, a node against itself, short paths through the root. The rest
        // go through the predictor: a longer path, a query across two separate
        // trees, and a node re-added elsewhere while its child still carries
        // the old depth and distance.
        directed_rows = '{
            make_row(OP_ADD,   10'd0,    10'd0,    16'hFFFF, PREDICTED, 32'd0,     10'd0),
            make_row(OP_QUERY, 10'd0,    10'd0,    16'h0000, TYPED,     32'd0,     10'd0),
            make_row(OP_ADD,   10'd1023, 10'd0,    16'hFFFF, PREDICTED, 32'd0,     10'd0),
            make_row(OP_QUERY, 10'd1023, 10'd0,    16'hFFFF, TYPED,     32'd65535, 10'd0),
            make_row(OP_QUERY, 10'd0,    10'd1023, 16'h0000, TYPED,     32'd65535, 10'd0),
            make_row(OP_ADD,   10'd512,  10'd1023, 16'h0000, PREDICTED, 32'd0,     10'd0),
            make_row(OP_ADD,   10'd341,  10'd0,    16'h0001, PREDICTED, 32'd0,     10'd0),
            make_row(OP_QUERY, 10'd512,  10'd341,  16'h0000, TYPED,     32'd65536, 10'd0),
            make_row(OP_QUERY, 10'd512,  10'd1023, 16'h0000, TYPED,     32'd0,     10'd1023),
            make_row(OP_ADD,   10'd682,  10'd512,  16'h5555, PREDICTED, 32'd0,     10'd0),
            make_row(OP_ADD,   10'd85,   10'd682,  16'hAAAA, PREDICTED, 32'd0,     10'd0),
            make_row(OP_QUERY, 10'd85,   10'd341,  16'h0000, PREDICTED, 32'd0,     10'd0),
            make_row(OP_QUERY, 10'd85,   10'd85,   16'h0000, TYPED,     32'd0,     10'd85),
            make_row(OP_ADD,   10'd2,    10'd2,    16'h0007, PREDICTED, 32'd0,     10'd0),
            make_row(OP_ADD,   10'd3,    10'd2,    16'h0009, PREDICTED, 32'd0,     10'd0),
            make_row(OP_QUERY, 10'd3,    10'd85,   16'h0000, PREDICTED, 32'd0,     10'd0),
            make_row(OP_ADD,   10'd682,  10'd341,  16'hFFFF, PREDICTED, 32'd0,     10'd0),
            make_row(OP_QUERY, 10'd85,   10'd682,  16'h0000, PREDICTED, 32'd0,     10'd0),
            make_row(OP_QUERY, 10'd682,  10'd341,  16'h0000, TYPED,     32'd65535, 10'd341),
            make_row(OP_ADD,   10'd0,    10'd0,    16'h1234, PREDICTED, 32'd0,     10'd0),
            make_row(OP_QUERY, 10'd1023, 10'd341,  16'h0000, TYPED,     32'd65536, 10'd0)
        };

        // Reset once, released on a rising edge.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
            send_item(directed_rows[i]);

        // Random forest traffic, with one long receiver hold in the middle
        // while the sender keeps offering queries.
        repeat (60) send_random_item();
        hold_requests <= hold_requests + 1;
        repeat (12) send_query(any_built(), any_built());
        repeat (60) send_random_item();
        wait_for_results();

        // One chain through every node in random order takes the depth to
        // its ceiling and gives lifts that use every jump level but the top. Two more
        // adds under the bottom of the chain must saturate instead of wrap.
        for (int i = 0; i < NODES; i++)
            chain_order[i] = node_t'(i);
        for (int i = NODES - 1; i > 0; i--)
        begin
            pick = $urandom_range(0, i);
            swap_tmp = chain_order[i];
            chain_order[i] = chain_order[pick];
            chain_order[pick] = swap_tmp;
        end
        send_add(chain_order[0], chain_order[0], rand_weight());
        for (int i = 1; i < NODES; i++)
        begin
            send_add(chain_order[i], chain_order[i - 1], rand_weight());
            if (i % 10 == 0)
                send_query(chain_order[$urandom_range(0, i)], chain_order[i]);
        end
        send_add(chain_order[3], chain_order[NODES - 1], rand_weight());
        send_add(chain_order[7], chain_order[3], rand_weight());
        repeat (60)
            send_query(chain_order[$urandom_range(0, NODES - 1)],
                       chain_order[$urandom_range(0, NODES - 1)]);
        wait_for_results();

        // A stretch with no idling on either side, then random idling again
        // with a second long hold.
        quiet_mode <= 1'b1;
        repeat (40) send_random_item();
        quiet_mode <= 1'b0;
        repeat (50) send_random_item();
        hold_requests <= hold_requests + 1;
        repeat (12) send_query(any_built(), any_built());
        repeat (50) send_random_item();

        wait_for_results();
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
rtl/tdl_pkg.sv
rtl/tdl_ram.sv
rtl/tree_distance_lca_binary_lifting.sv
tb/tree_distance_lca_binary_lifting_test.sv
